@@ rtl/core/fsch_pkg.sv @@
// Shared types, codes and constants of the free-space class histogram.
package fsch_pkg;

	localparam int FREE_W          = 16;
	localparam int DIV_W           = FREE_W - 1;
	localparam int CNT_W           = 17;
	localparam int PAGE_W          = 16;
	localparam int CLASS_SIZE_W    = 15;
	localparam int CLASS_COUNT_W   = 7;
	localparam int CFG_DATA_W      = 15;
	localparam int S_TDATA_W       = 48;
	localparam int M_TDATA_W       = 40;
	localparam int DEF_MAX_CLASSES = 64;
	localparam int DEF_PAGE_ID_BITS = 16;

	localparam logic [CNT_W-1:0]         CNT_MAX            = '1;
	localparam logic [CLASS_SIZE_W-1:0]  CLASS_SIZE_RESET   = 15'd64;
	localparam logic [CLASS_COUNT_W-1:0] CLASS_COUNT_RESET  = 7'd64;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_FOUND = 2'd0,
		STAT_NOWIT = 2'd1,
		STAT_NONE  = 2'd2,
		STAT_UPD   = 2'd3
	} stat_t;

	typedef enum logic {
		REG_CLASS_SIZE  = 1'b0,
		REG_CLASS_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_RD,
		ST_WB,
		ST_SCAN,
		ST_DONE
	} fsm_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

endpackage

@@ rtl/core/free_space_class_histogram_unit.sv @@
// Update: one class lookup for each side (old, new) whose free space is not negative, none with
// both absent; a lookup is a division on the shared 15-step divider, a RAM read and a write-back.
// Query: scans classes from the divided start (fewer than MAX_CLASSES of them), or from class 0
// with no division for a negative wanted space (at most MAX_CLASSES).
// One item in flight; the next is taken the cycle after the result is loaded.
// Reset clears counts, witness valid bits, page total, state and output valid; config back to 64.
module free_space_class_histogram_unit import fsch_pkg::*; #(
	parameter int MAX_CLASSES  = DEF_MAX_CLASSES,
	parameter int PAGE_ID_BITS = DEF_PAGE_ID_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // page_id[15:0], old_free[31:16], free_space[47:32]
	input  logic [0:0]            s_tuser,   // operation[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // witness_page[15:0], pages_tracked[32:16], zero pad
	output logic [1:0]            m_tuser    // status[1:0]
);

	localparam int CLS_W = $clog2(MAX_CLASSES);
	localparam int NW    = CLS_W + 1;

	fsm_t state_q, state_d;

	logic [CLASS_SIZE_W-1:0]  class_size_q;
	logic [CLASS_COUNT_W-1:0] class_count_q;

	op_t               op_q;
	logic [PAGE_ID_BITS-1:0] id_q;
	logic [FREE_W-1:0] old_q;
	logic [FREE_W-1:0] new_q;
	logic              phase_new_q;
	logic              div_use_new;
	logic [CLS_W-1:0]  loc_q;
	logic [NW-1:0]     scan_q;
	logic              scan_more;
	logic              chk_live_s1;
	logic [CLS_W-1:0]  raddr_s1;
	logic              found_q;
	logic              have_q;
	logic [PAGE_ID_BITS-1:0] wpage_q;
	logic [CNT_W-1:0]  pages_q;

	logic [MAX_CLASSES-1:0] cnt_vld_q;
	logic [MAX_CLASSES-1:0] wit_vld_q;

	logic              m_tvalid_q;
	stat_t             m_status_q;
	logic [PAGE_W-1:0] m_wit_q;
	logic [CNT_W-1:0]  m_pages_q;
	logic              out_load;

	logic [NW-1:0]     n_eff;
	logic [CLS_W-1:0]  top_c;
	logic [CLS_W-1:0]  cls_upd;
	logic [CLS_W-1:0]  cls_start;
	logic              at_top;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [CLS_W-1:0]        ram_raddr;
	logic [CNT_W-1:0]        cnt_rd;
	logic [PAGE_ID_BITS-1:0] wit_rd;
	logic [CNT_W-1:0]        cnt_eff;
	logic                    wit_ok;
	logic                    hit;
	logic                    cnt_we;
	logic [CNT_W-1:0]        cnt_wd;
	logic                    wit_we;

	// effective class count, clamped to 1..MAX_CLASSES
	always_comb begin
		if (class_count_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(class_count_q) > MAX_CLASSES) begin
			n_eff = NW'(MAX_CLASSES);
		end else begin
			n_eff = NW'(class_count_q);
		end
	end

	assign top_c     = CLS_W'(n_eff - NW'(1));
	assign at_top    = div_rsp.quot >= DIV_W'(top_c);
	assign cls_upd   = at_top ? top_c : CLS_W'(div_rsp.quot);
	assign cls_start = at_top ? top_c : CLS_W'(div_rsp.quot) + 1'b1;
	assign scan_more = scan_q < n_eff;

	assign ram_raddr = (state_q == ST_SCAN) ? scan_q[CLS_W-1:0] : loc_q;
	assign cnt_eff   = cnt_vld_q[raddr_s1] ? cnt_rd : '0;
	assign wit_ok    = wit_vld_q[raddr_s1];
	assign hit       = chk_live_s1 && (cnt_eff != '0) && wit_ok;

	assign cnt_we = state_q == ST_WB;
	assign wit_we = (state_q == ST_WB) && phase_new_q;
	always_comb begin
		if (phase_new_q) begin
			cnt_wd = (cnt_eff == CNT_MAX) ? cnt_eff : cnt_eff + 1'b1;
		end else begin
			cnt_wd = (cnt_eff == '0) ? cnt_eff : cnt_eff - 1'b1;
		end
	end

	fsch_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fsch_ram #(
		.WIDTH (CNT_W),
		.DEPTH (MAX_CLASSES)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (loc_q),
		.wdata (cnt_wd),
		.raddr (ram_raddr),
		.rdata (cnt_rd)
	);

	fsch_ram #(
		.WIDTH (PAGE_ID_BITS),
		.DEPTH (MAX_CLASSES)
	) u_wit_ram (
		.clk   (clk),
		.we    (wit_we),
		.waddr (loc_q),
		.wdata (id_q),
		.raddr (ram_raddr),
		.rdata (wit_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		div_req.start = 1'b0;
		div_use_new   = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (op_q == OP_QUERY) begin
					if (new_q[FREE_W-1]) begin
						state_d = ST_SCAN;
					end else begin
						div_req.start = 1'b1;
						div_use_new   = 1'b1;
						state_d       = ST_DIV;
					end
				end else if (!old_q[FREE_W-1]) begin
					div_req.start = 1'b1;
					state_d       = ST_DIV;
				end else if (!new_q[FREE_W-1]) begin
					div_req.start = 1'b1;
					div_use_new   = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = (op_q == OP_QUERY) ? ST_SCAN : ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_WB;
			end
			ST_WB: begin
				if (!phase_new_q && !new_q[FREE_W-1]) begin
					div_req.start = 1'b1;
					div_use_new   = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				if (hit || (!chk_live_s1 && !scan_more)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		div_req.divisor  = (class_size_q == '0) ? DIV_W'(1) : DIV_W'(class_size_q);
		div_req.dividend = div_use_new ? new_q[DIV_W-1:0] : old_q[DIV_W-1:0];
	end

	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_size_q  <= CLASS_SIZE_RESET;
			class_count_q <= CLASS_COUNT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CLASS_SIZE:  class_size_q  <= cfg_data[CLASS_SIZE_W-1:0];
				REG_CLASS_COUNT: class_count_q <= cfg_data[CLASS_COUNT_W-1:0];
			endcase
		end
	end

	// item capture and class bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_new_q <= 1'b0;
			chk_live_s1 <= 1'b0;
			found_q     <= 1'b0;
			have_q      <= 1'b0;
			pages_q     <= '0;
			cnt_vld_q   <= '0;
			wit_vld_q   <= '0;
			scan_q      <= '0;
		end else begin
			if (div_req.start) begin
				phase_new_q <= div_use_new;
			end
			chk_live_s1 <= 1'b0;
			unique case (state_q)
				ST_PREP: begin
					found_q <= 1'b0;
					have_q  <= 1'b0;
					scan_q  <= '0;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						scan_q <= {1'b0, cls_start};
					end
				end
				ST_WB: begin
					cnt_vld_q[loc_q] <= 1'b1;
					if (phase_new_q) begin
						wit_vld_q[loc_q] <= 1'b1;
						if (pages_q != CNT_MAX) begin
							pages_q <= pages_q + 1'b1;
						end
					end else begin
						if (wit_ok && (wit_rd == id_q)) begin
							wit_vld_q[loc_q] <= 1'b0;
						end
						if (pages_q != '0) begin
							pages_q <= pages_q - 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (scan_more && !hit) begin
						scan_q      <= scan_q + 1'b1;
						chk_live_s1 <= 1'b1;
					end
					if (chk_live_s1 && (cnt_eff != '0)) begin
						found_q <= 1'b1;
					end
					if (hit) begin
						have_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= ram_raddr;
		if (s_tvalid && s_tready) begin
			op_q  <= op_t'(s_tuser[0]);
			id_q  <= PAGE_ID_BITS'(s_tdata[PAGE_W-1:0]);
			old_q <= s_tdata[PAGE_W+FREE_W-1:PAGE_W];
			new_q <= s_tdata[PAGE_W+2*FREE_W-1:PAGE_W+FREE_W];
		end
		if ((state_q == ST_DIV) && div_rsp.done) begin
			loc_q <= cls_upd;
		end
		if (hit) begin
			wpage_q <= wit_rd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_pages_q <= pages_q;
			if (op_q == OP_UPDATE) begin
				m_status_q <= STAT_UPD;
				m_wit_q    <= '0;
			end else if (have_q) begin
				m_status_q <= STAT_FOUND;
				m_wit_q    <= PAGE_W'(wpage_q);
			end else begin
				m_status_q <= found_q ? STAT_NOWIT : STAT_NONE;
				m_wit_q    <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {(M_TDATA_W - PAGE_W - CNT_W)'(0), m_pages_q, m_wit_q};

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		chk_live_s1 |-> ({1'b0, raddr_s1} < n_eff))
		else $error("scan checked a class beyond the class count");

	a_update_no_witness: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == STAT_UPD)) |-> (m_tdata[PAGE_W-1:0] == '0))
		else $error("update result carries a witness page");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken while one is in flight");

	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside a class lookup");

	a_wb_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |-> ($past(state_q) == ST_RD))
		else $error("write-back without a fresh RAM read");

endmodule

@@ rtl/core/fsch_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fsch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/fsch_div.sv @@
// Restoring divider, one quotient bit per cycle, used for every class lookup.
module fsch_div import fsch_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CW = $clog2(DIV_W);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dq_q;
	logic [DIV_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   diff;
	logic             take;

	assign shifted = {rem_q, dq_q[DIV_W-1]};
	assign take    = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q  <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			dq_q  <= {dq_q[DIV_W-2:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dq_q;

endmodule
